### rtl/lcs_pkg.sv
// shared constants, types and character folding for the lcs length matcher
package lcs_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int CHAR_W      = 16;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int CELL_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 16'h0041;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 16'h005A;
  localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 16'h0020;

  // one text character travelling down the row of cells
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CHAR_W-1:0] t;
    logic [LEN_W-1:0]  n;
    logic [LEN_W-1:0]  up;
    logic [LEN_W-1:0]  diag;
  } beat_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      return c + ASCII_CASE_OFS;
    end
    return c;
  endfunction

endpackage

### rtl/lcs_if.sv
// valid/ready channel interfaces for the input and result streams
interface lcs_in_if import lcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0]  pattern_index;
  logic [CHAR_W-1:0] char_code;
  logic             last_char;

  modport source (output valid, action, pattern_index, char_code, last_char, input ready);
  modport sink   (input valid, action, pattern_index, char_code, last_char, output ready);
endinterface

interface lcs_out_if import lcs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [LEN_W-1:0] lcs_length;
  logic            full_match;

  modport source (output valid, lcs_length, full_match, input ready);
  modport sink   (input valid, lcs_length, full_match, output ready);
endinterface

### rtl/lcs_length_matcher_core.sv
// Longest common subsequence length between a stored pattern and streamed text.
// Input channel in_ch: a beat with action load writes char_code into pattern
// position pattern_index; a beat with action text feeds one text character.
// cfg_we/cfg_wdata write pattern_length (saturated to PATTERN_MAX internally).
// Text beats run down a row of PATTERN_MAX cells, one cell per cycle, so a new
// text character is taken every cycle unless a result waits on out_ch. A load
// beat is held off until no text beat is left in the row. The text beat marked
// last_char yields one result beat on out_ch (lcs_length, full_match); it passes
// through the cell registers and then the output register. Each cell clears its
// column entry as the last beat of a string passes it.
// Reset clears the column, pattern_length and the output valid flag; pattern
// contents are undefined until loaded. While a result waits on out_ch with
// ready low, the whole row holds and in_ch.ready stays low.
module lcs_length_matcher_core import lcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lcs_in_if.sink            in_ch,
  lcs_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata
);

  logic [LEN_W-1:0]       pattern_length_r;
  logic [LEN_W-1:0]       eff_len;
  logic                   out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]       out_lcs_r;
  logic                   out_full_r;
  logic                   adv;
  logic                   busy;
  logic                   accept;
  logic                   out_load;
  logic [PATTERN_MAX-1:0] pat_we;
  beat_t                  chain [PATTERN_MAX+1];
  beat_t                  tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
    end else if (cfg_we) begin
      pattern_length_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(pattern_length_r) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = pattern_length_r;
    end
  end

  // row moves unless a finished result is stuck at the output
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    busy = 1'b0;
    for (int i = 1; i <= PATTERN_MAX; i++) begin
      busy = busy | chain[i].valid;
    end
  end

  assign in_ch.ready = adv && ((in_ch.action == ACT_TEXT) || !busy);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    chain[0].valid = accept && (in_ch.action == ACT_TEXT);
    chain[0].last  = in_ch.last_char;
    chain[0].t     = fold_char(in_ch.char_code);
    chain[0].n     = eff_len;
    chain[0].up    = '0;
    chain[0].diag  = '0;
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    assign pat_we[i] = accept && (in_ch.action == ACT_LOAD) &&
                       (32'(in_ch.pattern_index) == i);

    lcs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (CELL_IDX_W'(i)),
      .pat_we   (pat_we[i]),
      .pat_char (in_ch.char_code),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  assign tail     = chain[PATTERN_MAX];
  assign out_load = adv && tail.valid && tail.last;

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lcs_r  <= tail.up;
      out_full_r <= (tail.up == tail.n);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.lcs_length = out_lcs_r;
  assign out_ch.full_match = out_full_r;

endmodule

### rtl/lcs_cell.sv
// one dp cell: holds a pattern character and its column entry, updates per text beat
module lcs_cell import lcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [CELL_IDX_W-1:0] cell_idx,
  input  logic                  pat_we,
  input  logic [CHAR_W-1:0]     pat_char,
  input  beat_t                 beat_in,
  output beat_t                 beat_out
);

  logic [CHAR_W-1:0] pat_r;
  logic [LEN_W-1:0]  col_r, col_nxt;
  beat_t             beat_r, beat_nxt;
  logic              active;
  logic              hit;
  logic [LEN_W-1:0]  nv;

  always_comb begin
    active = 32'(beat_in.n) > 32'(cell_idx);
    hit    = (pat_r == beat_in.t);
    if (hit) begin
      nv = beat_in.diag + LEN_W'(1);
    end else begin
      nv = (beat_in.up > col_r) ? beat_in.up : col_r;
    end

    col_nxt       = col_r;
    beat_nxt      = beat_in;
    beat_nxt.diag = col_r;
    if (beat_in.valid) begin
      // cells past the pattern length just carry the result along
      if (active) begin
        beat_nxt.up = nv;
        col_nxt     = nv;
      end
      if (beat_in.last) begin
        col_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
      col_r  <= '0;
    end else if (adv) begin
      beat_r <= beat_nxt;
      col_r  <= col_nxt;
    end
  end

  // pattern is stored already case-folded
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= fold_char(pat_char);
    end
  end

  assign beat_out = beat_r;

endmodule

### rtl/lcs_checker.sv
// port-level checks for the lcs length matcher, bound to the top level
module lcs_checker import lcs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  lcs_in_if.sink    in_ch,
  lcs_out_if.source out_ch
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result beat valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.lcs_length) && $stable(out_ch.full_match))
    else $error("stalled result beat changed");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 32'(out_ch.lcs_length) <= PATTERN_MAX)
    else $error("lcs length above pattern capacity");

endmodule

bind lcs_length_matcher_core lcs_checker u_lcs_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

### test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the lcs length matcher: random strings against a column predictor
module tb;
  import lcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = PATTERN_MAX + 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_PHASES     = 12;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  pidx;
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] lcs_length;
    logic             full_match;
  } score_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  lcs_in_if  in_ch ();
  lcs_out_if out_ch ();

  lcs_length_matcher_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [CHAR_W-1:0] model_pattern [PATTERN_MAX];
  logic [LEN_W-1:0]  model_column [PATTERN_MAX];
  logic [LEN_W-1:0]  model_len;
  score_t            pending_scores [$];

  // stimulus side
  char_beat_t        stim_q [$];
  logic [CHAR_W-1:0] stim_pattern [PATTERN_MAX];
  logic [CHAR_W-1:0] seed_chars [PATTERN_MAX];
  int                queued_cnt = 0;
  int                taken_cnt;
  int                src_gap;
  logic              src_calm;
  int                snk_gap;
  logic              snk_calm;
  int                hold_left;
  logic              hold_go;
  logic              hold_done;
  int                stuck_cycles;
  int                fail_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    return (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ? (c | ASCII_CASE_OFS) : c;
  endfunction

  // one column update per text beat, score pushed on the last beat of a string
  task automatic apply_beat(input char_beat_t b);
    int                n;
    int                diag;
    int                up;
    int                old;
    int                nv;
    int                lcs;
    logic [CHAR_W-1:0] t;
    score_t            s;
    if (b.action == ACT_LOAD) begin
      model_pattern[b.pidx] = b.code;
    end else begin
      n = (model_len > PATTERN_MAX) ? PATTERN_MAX : model_len;
      t = fold_case(b.code);
      diag = 0;
      up = 0;
      for (int i = 0; i < n; i++) begin
        old = model_column[i];
        if (fold_case(model_pattern[i]) == t) begin
          nv = diag + 1;
        end else begin
          nv = (up > old) ? up : old;
        end
        if (nv > 31) begin
          nv = 31;
        end
        diag = old;
        up = nv;
        model_column[i] = LEN_W'(nv);
      end
      if (b.last) begin
        lcs = (n == 0) ? 0 : model_column[n-1];
        s.lcs_length = LEN_W'(lcs);
        s.full_match = (lcs == n);
        pending_scores.push_back(s);
        foreach (model_column[i]) begin
          model_column[i] = '0;
        end
      end
    end
  endtask

  function automatic int draw_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic note_miss(input string what, input int want, input int got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    end
  endtask

  // input driver
  always @(posedge clk) begin : drive_in
    char_beat_t cur;
    char_beat_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= ACT_LOAD;
      in_ch.pattern_index <= '0;
      in_ch.char_code <= '0;
      in_ch.last_char <= 1'b0;
      src_gap <= 0;
      src_calm <= 1'b0;
      taken_cnt <= 0;
      foreach (model_column[i]) begin
        model_column[i] = '0;
        model_pattern[i] = '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur.action = in_ch.action;
        cur.pidx = in_ch.pattern_index;
        cur.code = in_ch.char_code;
        cur.last = in_ch.last_char;
        apply_beat(cur);
        taken_cnt <= taken_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.action <= nxt.action;
          in_ch.pattern_index <= nxt.pidx;
          in_ch.char_code <= nxt.code;
          in_ch.last_char <= nxt.last;
          src_gap <= draw_wait(src_calm);
          if ($urandom_range(0, 29) == 0) begin
            src_calm <= !src_calm;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk) begin : drive_out
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
      snk_calm <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      w = draw_wait(snk_calm);
      snk_gap <= w;
      out_ch.ready <= (w == 0);
      if ($urandom_range(0, 29) == 0) begin
        snk_calm <= !snk_calm;
      end
    end else if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      out_ch.ready <= (snk_gap == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : check_out
    score_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_scores.size() == 0) begin
        note_miss("unexpected beat lcs_length", -1, out_ch.lcs_length);
      end else begin
        want = pending_scores.pop_front();
        if (out_ch.lcs_length !== want.lcs_length) begin
          note_miss("lcs_length", want.lcs_length, out_ch.lcs_length);
        end
        if (out_ch.full_match !== want.full_match) begin
          note_miss("full_match", want.full_match, out_ch.full_match);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [CHAR_W-1:0] c,
                            input logic last);
    char_beat_t b;
    b.action = ACT_LOAD;
    b.pidx = idx;
    b.code = c;
    b.last = last;
    stim_pattern[idx] = c;
    queued_cnt++;
    stim_q.push_back(b);
  endtask

  task automatic queue_text(input logic [CHAR_W-1:0] c, input logic last);
    char_beat_t b;
    b.action = ACT_TEXT;
    b.pidx = IDX_W'($urandom_range(0, PATTERN_MAX - 1));
    b.code = c;
    b.last = last;
    queued_cnt++;
    stim_q.push_back(b);
  endtask

  // narrow alphabet mostly, so that strings share long subsequences with the pattern
  function automatic logic [CHAR_W-1:0] pattern_char();
    case ($urandom_range(0, 4))
      0: return CHAR_W'($urandom);
      1: return CHAR_W'($urandom_range(16'h0020, 16'h007E));
      default: return 16'h0041 + CHAR_W'($urandom_range(0, 3))
                      + ($urandom_range(0, 1) ? ASCII_CASE_OFS : 16'h0000);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] low;
    case ($urandom_range(0, 9))
      0: c = CHAR_W'($urandom);
      1: c = CHAR_W'($urandom_range(16'h003E, 16'h007D));
      2, 3: c = 16'h0061 + CHAR_W'($urandom_range(0, 3));
      default: begin
        c = stim_pattern[$urandom_range(0, PATTERN_MAX - 1)];
        low = c | ASCII_CASE_OFS;
        // swap case of letters half the time
        if (low >= 16'h0061 && low <= 16'h007A && $urandom_range(0, 1)) begin
          c = c ^ ASCII_CASE_OFS;
        end
      end
    endcase
    return c;
  endfunction

  task automatic queue_phase(input int budget);
    int made;
    int slen;
    made = 0;
    repeat ($urandom_range(0, 8)) begin
      queue_load(IDX_W'($urandom_range(0, PATTERN_MAX - 1)), pattern_char(),
                 1'($urandom_range(0, 1)));
      made++;
    end
    while (made < budget) begin
      slen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 12);
      for (int k = 0; k < slen; k++) begin
        // pattern rewrite in the middle of a string
        if ($urandom_range(0, 24) == 0) begin
          queue_load(IDX_W'($urandom_range(0, PATTERN_MAX - 1)), pattern_char(),
                     1'($urandom_range(0, 1)));
          made++;
        end
        queue_text(text_char(), k == slen - 1);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (queued_cnt != taken_cnt || pending_scores.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_len = v;
  endtask

  initial begin : main_seq
    int lens [NUM_PHASES];
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    hold_go = 1'b0;
    model_len = '0;
    foreach (stim_pattern[i]) begin
      stim_pattern[i] = '0;
    end
    seed_chars = '{16'h0041, 16'h007A, 16'h0040, 16'h005B, 16'h0000, 16'hFFFF, 16'h005A,
                   16'h0061, 16'h0062, 16'h0043, 16'h0064, 16'h0045, 16'h0066, 16'h0047,
                   16'h0068, 16'h0051};
    lens = '{1, 16, 31, 4, 0, 17, 8, 16, 2, 12, 16, 5};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fill every pattern cell, letter-range edges and code extremes, odd loads carry a last mark
    for (int p = 0; p < PATTERN_MAX; p++) begin
      queue_load(IDX_W'(p), seed_chars[p], p[0]);
    end
    // empty pattern after reset
    queue_text(16'h0041, 1'b1);

    // case folding, and a backquote that must not match the at sign
    write_len(3);
    queue_text(16'h0061, 1'b0);
    queue_text(16'h005A, 1'b0);
    queue_text(16'h0060, 1'b0);
    queue_text(16'h0040, 1'b1);

    // oversized length saturates to the full pattern
    write_len(31);
    queue_text(16'hFFFF, 1'b0);
    queue_text(16'h0000, 1'b0);
    queue_text(16'h005B, 1'b0);
    queue_text(16'h0048, 1'b1);

    for (int k = 0; k < NUM_PHASES; k++) begin
      write_len(LEN_W'(lens[k]));
      queue_phase(PHASE_ITEMS);
      if (k == 1) begin
        hold_go <= 1'b1;
      end
    end
    wait_drained();

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
